// File: design/imufr_pkg.sv
package imufr_pkg;

  localparam int FRAME_LEN   = 24;
  localparam int SYNC_LEN    = 4;
  localparam int SUM_FIRST   = 2;
  localparam int SUM_LAST    = 21;
  localparam int CHECK_IDX   = 22;
  localparam int FIRST_VALUE = 4;
  localparam int VALUE_COUNT = 9;
  localparam int STORE_LEN   = CHECK_IDX - FIRST_VALUE + 1;
  localparam int CNT_W       = $clog2(FRAME_LEN);
  localparam int VAL_W       = 17;

  localparam logic [15:0] HALF_SCALE = 16'h8000;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_END = 2'd1,
    ST_BAD_SUM = 2'd2
  } imufr_status_t;

  typedef enum logic {
    REG_SYNC_WORD  = 1'b0,
    REG_END_MARKER = 1'b1
  } imufr_reg_t;

  // finished frame handed from the tracker to the result stage
  typedef struct packed {
    logic                              emit;
    logic                              end_ok;
    logic                              sum_ok;
    logic [VALUE_COUNT-1:0][15:0]      raw;
  } imufr_frm_t;

endpackage

// File: design/imufr_if.sv
interface imufr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imufr_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         frame_status;
  logic signed [imufr_pkg::VAL_W-1:0] accel_x;
  logic signed [imufr_pkg::VAL_W-1:0] accel_y;
  logic signed [imufr_pkg::VAL_W-1:0] accel_z;
  logic signed [imufr_pkg::VAL_W-1:0] roll_rate;
  logic signed [imufr_pkg::VAL_W-1:0] pitch_rate;
  logic signed [imufr_pkg::VAL_W-1:0] yaw_rate;
  logic signed [imufr_pkg::VAL_W-1:0] mag_x;
  logic signed [imufr_pkg::VAL_W-1:0] mag_y;
  logic signed [imufr_pkg::VAL_W-1:0] mag_z;

  modport source (output valid, output frame_status, output accel_x, output accel_y,
                  output accel_z, output roll_rate, output pitch_rate, output yaw_rate,
                  output mag_x, output mag_y, output mag_z, input ready);
  modport sink   (input valid, input frame_status, input accel_x, input accel_y,
                  input accel_z, input roll_rate, input pitch_rate, input yaw_rate,
                  input mag_x, input mag_y, input mag_z, output ready);
endinterface

// File: design/imufr_apb.sv
module imufr_apb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] sync_word,
  output logic [7:0]  end_marker
);

  logic [31:0] sync_word_r;
  logic [7:0]  end_marker_r;
  logic        wr_en;
  imufr_pkg::imufr_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = imufr_pkg::imufr_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r  <= '0;
      end_marker_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        imufr_pkg::REG_SYNC_WORD:  sync_word_r  <= pwdata;
        imufr_pkg::REG_END_MARKER: end_marker_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      imufr_pkg::REG_SYNC_WORD:  prdata = sync_word_r;
      imufr_pkg::REG_END_MARKER: prdata = {24'b0, end_marker_r};
      default:                   prdata = '0;
    endcase
  end

  assign sync_word  = sync_word_r;
  assign end_marker = end_marker_r;

endmodule

// File: design/imufr_core.sv
module imufr_core (
  input  logic                  clk,
  input  logic                  rst_n,
  imufr_in_if.sink              in_bus,
  input  logic [31:0]           sync_word,
  input  logic [7:0]            end_marker,
  input  logic                  out_free,
  output imufr_pkg::imufr_frm_t frm
);

  localparam logic [imufr_pkg::CNT_W-1:0] CNT_LAST =
    imufr_pkg::CNT_W'(imufr_pkg::FRAME_LEN - 1);
  localparam logic [imufr_pkg::CNT_W-1:0] CNT_SYNC =
    imufr_pkg::CNT_W'(imufr_pkg::SYNC_LEN);
  localparam logic [imufr_pkg::CNT_W-1:0] CNT_SUM_LO =
    imufr_pkg::CNT_W'(imufr_pkg::SUM_FIRST);
  localparam logic [imufr_pkg::CNT_W-1:0] CNT_SUM_HI =
    imufr_pkg::CNT_W'(imufr_pkg::SUM_LAST);

  logic                          s1_vld_r;
  logic [7:0]                    s1_byte_r;
  logic [imufr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [23:0]                   win_r, win_nxt;
  logic [7:0]                    sum_r, sum_nxt;
  logic [7:0]                    store_r [imufr_pkg::STORE_LEN];
  logic [31:0]                   win_full;
  logic                          hunting, last_byte, s1_go;

  assign hunting   = (cnt_r == '0);
  assign last_byte = (cnt_r == CNT_LAST);
  // a non-final byte never needs room in the result register
  assign s1_go     = s1_vld_r && (!last_byte || out_free);
  assign in_bus.ready = !s1_vld_r || s1_go;
  assign win_full  = {win_r, s1_byte_r};

  always_comb begin
    cnt_nxt = cnt_r;
    win_nxt = win_r;
    sum_nxt = sum_r;
    if (hunting) begin
      win_nxt = win_full[23:0];
      if (win_full == sync_word) begin
        cnt_nxt = CNT_SYNC;
        sum_nxt = win_full[15:8] + s1_byte_r;
      end
    end else begin
      if (cnt_r >= CNT_SUM_LO && cnt_r <= CNT_SUM_HI) begin
        sum_nxt = sum_r + s1_byte_r;
      end
      cnt_nxt = last_byte ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      cnt_r    <= '0;
      win_r    <= '0;
      sum_r    <= '0;
    end else begin
      if (in_bus.ready) begin
        s1_vld_r <= in_bus.valid;
      end
      if (s1_go) begin
        cnt_r <= cnt_nxt;
        win_r <= win_nxt;
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_byte_r <= in_bus.rx_byte;
    end
  end

  // frame bytes from the first value byte up to the checksum byte
  always_ff @(posedge clk) begin
    for (int i = 0; i < imufr_pkg::STORE_LEN; i++) begin
      if (s1_go && cnt_r == imufr_pkg::CNT_W'(imufr_pkg::FIRST_VALUE + i)) begin
        store_r[i] <= s1_byte_r;
      end
    end
  end

  always_comb begin
    frm.emit   = s1_go && last_byte;
    frm.end_ok = (s1_byte_r == end_marker);
    frm.sum_ok = (sum_r == store_r[imufr_pkg::CHECK_IDX - imufr_pkg::FIRST_VALUE]);
    for (int j = 0; j < imufr_pkg::VALUE_COUNT; j++) begin
      frm.raw[j] = {store_r[2*j], store_r[2*j + 1]};
    end
  end

endmodule

// File: design/imufr_out.sv
module imufr_out (
  input  logic                  clk,
  input  logic                  rst_n,
  input  imufr_pkg::imufr_frm_t frm,
  output logic                  out_free,
  imufr_out_if.source           out_bus
);

  typedef logic signed [imufr_pkg::VAL_W-1:0] val_t;

  logic                  out_vld_r;
  imufr_pkg::imufr_status_t status_r, status_nxt;
  val_t                  val_r   [imufr_pkg::VALUE_COUNT];
  val_t                  val_nxt [imufr_pkg::VALUE_COUNT];

  // sign-magnitude with the top code kept as +32768
  function automatic val_t decode(input logic [15:0] u);
    val_t v;
    if (u > imufr_pkg::HALF_SCALE) begin
      v = val_t'({1'b0, imufr_pkg::HALF_SCALE}) - val_t'({1'b0, u});
    end else begin
      v = val_t'({1'b0, u});
    end
    return v;
  endfunction

  assign out_free = !out_vld_r || out_bus.ready;

  always_comb begin
    if (!frm.end_ok) begin
      status_nxt = imufr_pkg::ST_BAD_END;
    end else if (!frm.sum_ok) begin
      status_nxt = imufr_pkg::ST_BAD_SUM;
    end else begin
      status_nxt = imufr_pkg::ST_GOOD;
    end
    for (int j = 0; j < imufr_pkg::VALUE_COUNT; j++) begin
      val_nxt[j] = (status_nxt == imufr_pkg::ST_GOOD) ? decode(frm.raw[j]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (frm.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frm.emit) begin
      status_r <= status_nxt;
      for (int j = 0; j < imufr_pkg::VALUE_COUNT; j++) begin
        val_r[j] <= val_nxt[j];
      end
    end
  end

  assign out_bus.valid        = out_vld_r;
  assign out_bus.frame_status = status_r;
  assign out_bus.accel_x      = val_r[0];
  assign out_bus.accel_y      = val_r[1];
  assign out_bus.accel_z      = val_r[2];
  assign out_bus.roll_rate    = val_r[3];
  assign out_bus.pitch_rate   = val_r[4];
  assign out_bus.yaw_rate     = val_r[5];
  assign out_bus.mag_x        = val_r[6];
  assign out_bus.mag_y        = val_r[7];
  assign out_bus.mag_z        = val_r[8];

endmodule

// File: design/imu_frame_receiver_unit.sv
// a result is registered from the last frame byte: the byte sits in the input register,
// and the result register loads from it once no held result is waiting there
// throughput: one byte per cycle; the frame tracker updates once per byte
// a held result stalls input only when the final byte of the next frame arrives
// reset (synchronous, rst_n low): hunting for sync, window and sum cleared,
// sync_word and end_marker cleared, no result pending
module imu_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  imufr_in_if.sink    in_bus,
  imufr_out_if.source out_bus,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]           sync_word;
  logic [7:0]            end_marker;
  logic                  out_free;
  imufr_pkg::imufr_frm_t frm;

  imufr_apb u_apb (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .sync_word  (sync_word),
    .end_marker (end_marker)
  );

  imufr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .sync_word  (sync_word),
    .end_marker (end_marker),
    .out_free   (out_free),
    .frm        (frm)
  );

  imufr_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .frm      (frm),
    .out_free (out_free),
    .out_bus  (out_bus)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int PHASES      = 8;
  localparam int PHASE_BYTES = 160;

  typedef struct packed {
    imufr_pkg::imufr_status_t                                 status;
    logic [imufr_pkg::VALUE_COUNT-1:0][imufr_pkg::VAL_W-1:0] vals;
  } frame_result_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  imufr_in_if  in_bus ();
  imufr_out_if out_bus ();

  imu_frame_receiver_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver model state
  logic [31:0]   sync_reg;
  logic [7:0]    end_reg;
  int            frame_pos;
  logic [23:0]   hunt_window;
  logic [7:0]    frame_sum;
  logic [7:0]    frame_bytes [imufr_pkg::FRAME_LEN];
  frame_result_t pending_frames [$];

  logic [7:0] tx_bytes [$];
  int         bytes_queued;
  int         bytes_taken;
  int         in_gap;
  int         out_stall;
  bit         in_sent;
  bit         out_sent;
  bit         in_smooth;
  bit         out_smooth;
  int         errors;
  int         n_good;
  int         n_bad_end;
  int         n_bad_sum;

  string value_name [imufr_pkg::VALUE_COUNT] = '{"accel_x", "accel_y", "accel_z",
                                                 "roll_rate", "pitch_rate", "yaw_rate",
                                                 "mag_x", "mag_y", "mag_z"};

  task automatic report_miss(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10) begin
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  function automatic logic [imufr_pkg::VAL_W-1:0] decode_pair(logic [7:0] hi, logic [7:0] lo);
    logic [15:0] u;
    u = {hi, lo};
    if (u > imufr_pkg::HALF_SCALE) begin
      return -{1'b0, 16'(u - imufr_pkg::HALF_SCALE)};
    end
    return {1'b0, u};
  endfunction

  function automatic void track_byte(logic [7:0] b);
    logic [31:0]   w;
    frame_result_t r;
    if (frame_pos == 0) begin
      w = {hunt_window, b};
      hunt_window = w[23:0];
      if (w == sync_reg) begin
        frame_bytes[0] = w[31:24];
        frame_bytes[1] = w[23:16];
        frame_bytes[2] = w[15:8];
        frame_bytes[3] = w[7:0];
        frame_sum = w[15:8] + b;
        frame_pos = imufr_pkg::SYNC_LEN;
      end
    end else begin
      frame_bytes[frame_pos] = b;
      if (frame_pos >= imufr_pkg::SUM_FIRST && frame_pos <= imufr_pkg::SUM_LAST) begin
        frame_sum = frame_sum + b;
      end
      frame_pos++;
      if (frame_pos == imufr_pkg::FRAME_LEN) begin
        frame_pos = 0;
        r = '0;
        if (frame_bytes[imufr_pkg::FRAME_LEN-1] != end_reg) begin
          r.status = imufr_pkg::ST_BAD_END;
        end else if (frame_sum != frame_bytes[imufr_pkg::CHECK_IDX]) begin
          r.status = imufr_pkg::ST_BAD_SUM;
        end else begin
          r.status = imufr_pkg::ST_GOOD;
          for (int j = 0; j < imufr_pkg::VALUE_COUNT; j++) begin
            r.vals[j] = decode_pair(frame_bytes[imufr_pkg::FIRST_VALUE + 2*j],
                                    frame_bytes[imufr_pkg::FIRST_VALUE + 2*j + 1]);
          end
        end
        pending_frames.push_back(r);
      end
    end
  endfunction

  task automatic check_frame();
    frame_result_t want;
    frame_result_t got;
    got.status  = imufr_pkg::imufr_status_t'(out_bus.frame_status);
    got.vals[0] = out_bus.accel_x;
    got.vals[1] = out_bus.accel_y;
    got.vals[2] = out_bus.accel_z;
    got.vals[3] = out_bus.roll_rate;
    got.vals[4] = out_bus.pitch_rate;
    got.vals[5] = out_bus.yaw_rate;
    got.vals[6] = out_bus.mag_x;
    got.vals[7] = out_bus.mag_y;
    got.vals[8] = out_bus.mag_z;
    case (got.status)
      imufr_pkg::ST_GOOD:    n_good++;
      imufr_pkg::ST_BAD_END: n_bad_end++;
      default:               n_bad_sum++;
    endcase
    if (pending_frames.size() == 0) begin
      report_miss("unexpected frame result, status", 32'(imufr_pkg::ST_GOOD),
                  32'(got.status));
    end else begin
      want = pending_frames.pop_front();
      if (want.status !== got.status) begin
        report_miss("frame_status", 32'(want.status), 32'(got.status));
      end
      for (int j = 0; j < imufr_pkg::VALUE_COUNT; j++) begin
        if (want.vals[j] !== got.vals[j]) begin
          report_miss(value_name[j], 32'(want.vals[j]), 32'(got.vals[j]));
        end
      end
    end
  endtask

  // result check first: a result never belongs to the byte of the same edge
  always @(posedge clk) begin
    in_sent  = rst_n && in_bus.valid && in_bus.ready;
    out_sent = rst_n && out_bus.valid && out_bus.ready;
    if (out_sent) begin
      check_frame();
    end
    if (in_sent) begin
      track_byte(in_bus.rx_byte);
      bytes_taken++;
    end
  end

  always @(negedge clk) begin : drive_bytes
    logic       nv;
    logic [7:0] nb;
    nv = in_bus.valid;
    nb = in_bus.rx_byte;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_bus.valid || in_sent) begin
      if (in_gap > 0) begin
        in_gap--;
        nv = 1'b0;
      end else if (tx_bytes.size() > 0) begin
        nb = tx_bytes.pop_front();
        nv = 1'b1;
        in_gap = in_smooth ? 0 : $urandom_range(0, 4);
      end else begin
        nv = 1'b0;
      end
    end
    in_bus.valid   <= nv;
    in_bus.rx_byte <= nb;
  end

  always @(negedge clk) begin : drive_ready
    logic nr;
    nr = 1'b0;
    if (rst_n) begin
      if (out_sent) begin
        out_stall = out_smooth ? 0 : $urandom_range(0, 4);
      end
      if (out_stall > 0) begin
        out_stall--;
      end else begin
        nr = 1'b1;
      end
    end
    out_bus.ready <= nr;
  end

  function automatic void queue_byte(logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endfunction

  // lead = sync bytes sent (the window may already hold the rest),
  // cut = frame bytes sent before stopping
  task automatic queue_frame(logic [31:0] sw, logic [7:0] em,
                             imufr_pkg::imufr_status_t flaw,
                             bit pick_edges, int lead, int cut);
    logic [7:0]  f [imufr_pkg::FRAME_LEN];
    logic [7:0]  s;
    logic [15:0] v;
    logic [15:0] edge_vals [imufr_pkg::VALUE_COUNT];
    edge_vals = '{16'h0000, 16'h8000, 16'h8001, 16'hFFFF, 16'h7FFF,
                  16'h0001, 16'h00FF, 16'hFF00, 16'h7F80};
    f[0] = sw[31:24];
    f[1] = sw[23:16];
    f[2] = sw[15:8];
    f[3] = sw[7:0];
    for (int j = 0; j < imufr_pkg::VALUE_COUNT; j++) begin
      if (pick_edges) begin
        v = edge_vals[j];
      end else begin
        case ($urandom_range(0, 7))
          0:       v = 16'h0000;
          1:       v = 16'h8000;
          2:       v = 16'h8001;
          3:       v = 16'hFFFF;
          4:       v = 16'h7FFF;
          default: v = 16'($urandom());
        endcase
      end
      f[imufr_pkg::FIRST_VALUE + 2*j]     = v[15:8];
      f[imufr_pkg::FIRST_VALUE + 2*j + 1] = v[7:0];
    end
    s = '0;
    for (int k = imufr_pkg::SUM_FIRST; k <= imufr_pkg::SUM_LAST; k++) begin
      s = s + f[k];
    end
    f[imufr_pkg::CHECK_IDX]   = s;
    f[imufr_pkg::FRAME_LEN-1] = em;
    if (flaw == imufr_pkg::ST_BAD_SUM ||
        (flaw == imufr_pkg::ST_BAD_END && $urandom_range(0, 1))) begin
      f[imufr_pkg::CHECK_IDX] = s + 8'($urandom_range(1, 255));
    end
    if (flaw == imufr_pkg::ST_BAD_END) begin
      f[imufr_pkg::FRAME_LEN-1] = em ^ 8'($urandom_range(1, 255));
    end
    for (int k = imufr_pkg::SYNC_LEN - lead; k < cut; k++) begin
      queue_byte(f[k]);
    end
  endtask

  task automatic cfg_access(imufr_pkg::imufr_reg_t idx, logic wr, logic [31:0] data,
                            output logic [31:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(imufr_pkg::imufr_reg_t idx, logic [31:0] data);
    logic [31:0] rd;
    cfg_access(idx, 1'b1, data, rd);
    if (idx == imufr_pkg::REG_SYNC_WORD) begin
      sync_reg = data;
    end else begin
      end_reg = data[7:0];
    end
    cfg_access(idx, 1'b0, '0, rd);
    if (rd !== data) begin
      report_miss(idx == imufr_pkg::REG_SYNC_WORD ? "sync_word readback"
                                                  : "end_marker readback",
                  data, rd);
    end
  endtask

  // no result is expected and the last byte has had time to settle
  task automatic wait_quiet();
    while (tx_bytes.size() != 0 || in_bus.valid || pending_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [31:0] sw;
    logic [7:0]  em;
    int          stop_at;
    int          lead;
    clk            = 1'b0;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    out_bus.ready  = 1'b0;
    sync_reg       = '0;
    end_reg        = '0;
    frame_pos      = 0;
    hunt_window    = '0;
    frame_sum      = '0;
    bytes_queued   = 0;
    bytes_taken    = 0;
    in_gap         = 0;
    out_stall      = 0;
    in_smooth      = 1'b0;
    out_smooth     = 1'b0;
    errors         = 0;
    n_good         = 0;
    n_bad_end      = 0;
    n_bad_sum      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero sync word out of reset: the first zero byte locks right away
    queue_frame('0, '0, imufr_pkg::ST_GOOD, 1'b1, 1, imufr_pkg::FRAME_LEN);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    wait_quiet();

    for (int p = 0; p < PHASES; p++) begin
      sw = (p == 0) ? 32'hFFFF_FFFF : (p == 2) ? 32'h0 : $urandom();
      em = (p == 0) ? 8'hFF : (p == 2) ? 8'h00 : 8'($urandom_range(0, 255));
      write_reg(imufr_pkg::REG_SYNC_WORD, sw);
      write_reg(imufr_pkg::REG_END_MARKER, {24'b0, em});
      in_smooth  = ($urandom_range(0, 3) == 0);
      out_smooth = ($urandom_range(0, 3) == 0);
      stop_at = bytes_queued + PHASE_BYTES;
      while (bytes_queued < stop_at) begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 6)) queue_byte(8'($urandom()));
          end
          1: begin
            // sync that breaks off early
            lead = $urandom_range(1, 3);
            for (int k = 0; k < lead; k++) begin
              queue_byte(sw[31 - 8*k -: 8]);
            end
            queue_byte(8'($urandom()));
          end
          2: queue_frame(sw, em, imufr_pkg::ST_BAD_END, 1'b0, imufr_pkg::SYNC_LEN,
                         imufr_pkg::FRAME_LEN);
          3: queue_frame(sw, em, imufr_pkg::ST_BAD_SUM, 1'b0, imufr_pkg::SYNC_LEN,
                         imufr_pkg::FRAME_LEN);
          default: queue_frame(sw, em, imufr_pkg::ST_GOOD, 1'b0, imufr_pkg::SYNC_LEN,
                               imufr_pkg::FRAME_LEN);
        endcase
      end
      // leave a frame open so the next register writes land mid-frame
      if (p % 2 == 1) begin
        queue_frame(sw, em, imufr_pkg::ST_GOOD, 1'b0, imufr_pkg::SYNC_LEN,
                    $urandom_range(6, 20));
      end
      wait_quiet();
    end

    repeat (8) @(posedge clk);
    $display("sent %0d bytes over %0d register settings", bytes_taken, PHASES + 1);
    $display("frames: %0d good, %0d bad end byte, %0d bad checksum; %0d mismatches",
             n_good, n_bad_end, n_bad_sum, errors);
    if (errors == 0 && pending_frames.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
